FILE: sv/ft12_link_frame_receiver_defines.svh
// Assertion macros for the FT1.2 link frame receiver
`ifndef FT12_LINK_FRAME_RECEIVER_DEFINES_SVH
`define FT12_LINK_FRAME_RECEIVER_DEFINES_SVH

// Condition implies consequence in the same cycle
`define FT12_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle
`define FT12_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ft12_pkg.sv
// Types and constants shared by the FT1.2 link frame receiver
`timescale 1ns / 1ps

package ft12_pkg;

    localparam int ACTION_W       = 2;
    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 4;
    localparam int TIMEOUT_W      = 15;
    localparam int IDLE_W         = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 15;
    localparam int HDR_DEPTH      = 6;
    localparam int HDR_IDX_W      = 3;

    localparam int DEF_BUF_SIZE      = 255;
    localparam int DEF_MIN_VAR_FRAME = 8;

    localparam logic [BYTE_W-1:0] START_FIX = 8'h10;
    localparam logic [BYTE_W-1:0] START_VAR = 8'h68;
    localparam logic [BYTE_W-1:0] STOP_CHAR = 8'h16;
    localparam logic [BYTE_W-1:0] FIX_LEN   = 8'd5;
    localparam logic [BYTE_W-1:0] VAR_HDR   = 8'd6;
    localparam logic [BYTE_W-1:0] SUM_START = 8'd4;
    localparam int                PRM_BIT   = 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BYTE  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_REARM = 2'd2
    } ft12_action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OWN_ADDR   = 2'd0,
        REG_BCAST_ADDR = 2'd1,
        REG_TIMEOUT    = 2'd2
    } ft12_reg_t;

    typedef enum logic [3:0] {
        MODE_OFF  = 4'b0001,
        MODE_READ = 4'b0010,
        MODE_OK   = 4'b0100,
        MODE_ERR  = 4'b1000
    } ft12_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 4'd0,
        ST_SHORT    = 4'd1,
        ST_SIZE     = 4'd2,
        ST_STOP     = 4'd3,
        ST_CHECKSUM = 4'd4,
        ST_ADDRESS  = 4'd5,
        ST_PRM      = 4'd6,
        ST_LEN_PAIR = 4'd7,
        ST_LEN_CNT  = 4'd8,
        ST_START2   = 4'd9
    } ft12_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    own_address;
        logic [BYTE_W-1:0]    broadcast_address;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } ft12_cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   byte_value;
    } ft12_item_t;

    typedef struct packed {
        ft12_status_t      status;
        logic              is_variable;
        logic [BYTE_W-1:0] control_byte;
        logic [BYTE_W-1:0] link_address;
        logic [BYTE_W-1:0] byte_count;
    } ft12_result_t;

    typedef struct packed {
        ft12_mode_t        mode;
        logic [BYTE_W-1:0] count;
    } ft12_state_t;

endpackage

FILE: sv/ft12_if.sv
// Valid/ready channel interfaces for input items and result items
`timescale 1ns / 1ps

interface ft12_item_if;
    logic                            valid;
    logic                            ready;
    logic [ft12_pkg::ACTION_W-1:0]   action;
    logic [ft12_pkg::BYTE_W-1:0]     byte_value;

    modport source (output valid, output action, output byte_value, input ready);
    modport sink   (input valid, input action, input byte_value, output ready);
endinterface

interface ft12_result_if;
    logic                            valid;
    logic                            ready;
    logic [ft12_pkg::STATUS_W-1:0]   status;
    logic                            is_variable;
    logic [ft12_pkg::BYTE_W-1:0]     control_byte;
    logic [ft12_pkg::BYTE_W-1:0]     link_address;
    logic [ft12_pkg::BYTE_W-1:0]     byte_count;

    modport source (output valid, output status, output is_variable, output control_byte,
                    output link_address, output byte_count, input ready);
    modport sink   (input valid, input status, input is_variable, input control_byte,
                    input link_address, input byte_count, output ready);
endinterface

FILE: sv/ft12_link_frame_receiver.sv
// Flow: an accepted request waits in the input register until the core takes it; the result
// of the tick that ends a frame is then held in the result register until it is taken.
// Throughput: one request per cycle; the input register and the result register let a new
// request in while a result waits, and the core stalls only while that result is not taken.
// Reset: mode off, counts and sums cleared, registers at their reset values; header
// bytes are not cleared.
`timescale 1ns / 1ps

`include "ft12_link_frame_receiver_defines.svh"

module ft12_link_frame_receiver #(
    parameter int BUF_SIZE      = ft12_pkg::DEF_BUF_SIZE,
    parameter int MIN_VAR_FRAME = ft12_pkg::DEF_MIN_VAR_FRAME
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ft12_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ft12_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    ft12_item_if.sink                       item,
    ft12_result_if.source                   result
);
    import ft12_pkg::*;

    localparam logic [BYTE_W-1:0] BUF_LIM = BYTE_W'(BUF_SIZE);

    ft12_cfg_t    cfg_reg;
    ft12_item_t   in_item;
    ft12_item_t   cur_item;
    logic         cur_valid;
    logic         fire;
    logic         res_valid;
    ft12_result_t res;
    ft12_result_t out_res;
    logic         out_valid;
    ft12_state_t  state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address       <= 8'd0;
            cfg_reg.broadcast_address <= 8'd255;
            cfg_reg.timeout_ticks     <= 15'd32767;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_OWN_ADDR:   cfg_reg.own_address       <= cfg_wr_data[BYTE_W-1:0];
                REG_BCAST_ADDR: cfg_reg.broadcast_address <= cfg_wr_data[BYTE_W-1:0];
                REG_TIMEOUT:    cfg_reg.timeout_ticks     <= cfg_wr_data[TIMEOUT_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_item.action     = item.action;
    assign in_item.byte_value = item.byte_value;

    // Advance the core only when the result register is free or being drained
    assign fire = cur_valid && (!out_valid || result.ready);

    ft12_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item.valid),
        .in_ready   (item.ready),
        .in_item    (in_item),
        .fire       (fire),
        .item_valid (cur_valid),
        .item       (cur_item)
    );

    ft12_core #(
        .BUF_SIZE      (BUF_SIZE),
        .MIN_VAR_FRAME (MIN_VAR_FRAME)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (cur_item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res),
        .state     (state)
    );

    ft12_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign result.valid        = out_valid;
    assign result.status       = out_res.status;
    assign result.is_variable  = out_res.is_variable;
    assign result.control_byte = out_res.control_byte;
    assign result.link_address = out_res.link_address;
    assign result.byte_count   = out_res.byte_count;

    `FT12_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid && !result.ready,
        $stable(state.mode), "frame state advanced while a result was stalled")
    `FT12_ASSERT_NEXT(a_result_mode, clk, rst_n, fire && res_valid,
        state.mode == MODE_OK || state.mode == MODE_ERR, "result did not leave listening")
    `FT12_ASSERT_SAME(a_result_from_tick, clk, rst_n, $rose(out_valid),
        $past(fire && cur_item.action == ACT_TICK), "result without a tick request")
    `FT12_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1,
        state.count <= BUF_LIM, "stored byte count beyond buffer size")

endmodule

FILE: sv/ft12_in_stage.sv
// Input register that holds one request until the core takes it
`timescale 1ns / 1ps

module ft12_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ft12_pkg::ft12_item_t in_item,
    input  logic                 fire,
    output logic                 item_valid,
    output ft12_pkg::ft12_item_t item
);
    import ft12_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    ft12_item_t item_reg;

    assign in_ready   = !valid_reg || fire;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: sv/ft12_core.sv
// Frame state, header store and frame checks; one request per cycle while fire is high
`timescale 1ns / 1ps

module ft12_core #(
    parameter int BUF_SIZE      = ft12_pkg::DEF_BUF_SIZE,
    parameter int MIN_VAR_FRAME = ft12_pkg::DEF_MIN_VAR_FRAME
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  ft12_pkg::ft12_item_t   item,
    input  ft12_pkg::ft12_cfg_t    cfg,
    output logic                   res_valid,
    output ft12_pkg::ft12_result_t res,
    output ft12_pkg::ft12_state_t  state
);
    import ft12_pkg::*;

    localparam logic [BYTE_W-1:0] BUF_LIM = BYTE_W'(BUF_SIZE);
    localparam logic [BYTE_W-1:0] MIN_VAR = BYTE_W'(MIN_VAR_FRAME);

    ft12_mode_t        mode_reg,   mode_next;
    logic [BYTE_W-1:0] count_reg,  count_next;
    logic [IDLE_W-1:0] idle_reg,   idle_next;
    logic [BYTE_W-1:0] sum_reg,    sum_next;
    logic [BYTE_W-1:0] last_reg,   last_next;
    logic [BYTE_W-1:0] before_reg, before_next;
    logic [BYTE_W-1:0] hdr_reg [HDR_DEPTH];

    logic              hdr_we;
    logic [IDLE_W-1:0] idle_inc;
    logic              addr_fix_ok;
    logic              addr_var_ok;
    logic [BYTE_W-1:0] crc;
    ft12_status_t      fix_status;
    ft12_status_t      var_status;
    ft12_result_t      frame_res;

    assign state.mode  = mode_reg;
    assign state.count = count_reg;

    assign idle_inc    = (idle_reg == '1) ? idle_reg : idle_reg + IDLE_W'(1);
    assign addr_fix_ok = (hdr_reg[2] == cfg.own_address) || (hdr_reg[2] == cfg.broadcast_address);
    assign addr_var_ok = (hdr_reg[5] == cfg.own_address) || (hdr_reg[5] == cfg.broadcast_address);
    assign crc         = sum_reg - last_reg - before_reg;

    // Fixed frame: first failing check wins
    always_comb
    begin
        if (count_reg != FIX_LEN)
            fix_status = ST_SIZE;
        else if (hdr_reg[4] != STOP_CHAR)
            fix_status = ST_STOP;
        else if (hdr_reg[3] != BYTE_W'(hdr_reg[1] + hdr_reg[2]))
            fix_status = ST_CHECKSUM;
        else if (!addr_fix_ok)
            fix_status = ST_ADDRESS;
        else if (!hdr_reg[1][PRM_BIT])
            fix_status = ST_PRM;
        else
            fix_status = ST_OK;
    end

    // Variable frame: first failing check wins
    always_comb
    begin
        if (count_reg < MIN_VAR)
            var_status = ST_SIZE;
        else if (hdr_reg[1] != hdr_reg[2])
            var_status = ST_LEN_PAIR;
        else if (hdr_reg[1] != BYTE_W'(count_reg - VAR_HDR))
            var_status = ST_LEN_CNT;
        else if (hdr_reg[3] != START_VAR)
            var_status = ST_START2;
        else if (!addr_var_ok)
            var_status = ST_ADDRESS;
        else if (last_reg != STOP_CHAR)
            var_status = ST_STOP;
        else if (before_reg != crc)
            var_status = ST_CHECKSUM;
        else if (!hdr_reg[4][PRM_BIT])
            var_status = ST_PRM;
        else
            var_status = ST_OK;
    end

    // Result fields; absent header bytes read as zero
    always_comb
    begin
        frame_res            = '0;
        frame_res.status     = ST_SHORT;
        frame_res.byte_count = count_reg;
        if (hdr_reg[0] == START_FIX)
        begin
            if (count_reg > 8'd1)
                frame_res.control_byte = hdr_reg[1];
            if (count_reg > 8'd2)
                frame_res.link_address = hdr_reg[2];
            if (count_reg >= FIX_LEN)
                frame_res.status = fix_status;
        end
        else if (hdr_reg[0] == START_VAR)
        begin
            frame_res.is_variable = 1'b1;
            if (count_reg > 8'd4)
                frame_res.control_byte = hdr_reg[4];
            if (count_reg > 8'd5)
                frame_res.link_address = hdr_reg[5];
            if (count_reg >= FIX_LEN)
                frame_res.status = var_status;
        end
    end

    assign res = frame_res;

    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        idle_next   = idle_reg;
        sum_next    = sum_reg;
        last_next   = last_reg;
        before_next = before_reg;
        hdr_we      = 1'b0;
        res_valid   = 1'b0;
        if (fire)
        begin
            case (item.action)
                ACT_BYTE:
                begin
                    if (mode_reg == MODE_READ)
                    begin
                        if (count_reg < BUF_LIM)
                        begin
                            hdr_we      = (count_reg < BYTE_W'(HDR_DEPTH));
                            before_next = last_reg;
                            last_next   = item.byte_value;
                            count_next  = count_reg + BYTE_W'(1);
                            if (count_reg >= SUM_START)
                                sum_next = sum_reg + item.byte_value;
                        end
                        idle_next = '0;
                    end
                end
                ACT_TICK:
                begin
                    idle_next = idle_inc;
                    if (mode_reg == MODE_ERR)
                    begin
                        // Listen again after twice the timeout
                        if (idle_inc >= {cfg.timeout_ticks, 1'b0})
                        begin
                            mode_next   = MODE_READ;
                            count_next  = '0;
                            idle_next   = '0;
                            sum_next    = '0;
                            last_next   = '0;
                            before_next = '0;
                        end
                    end
                    else if (mode_reg == MODE_READ && idle_inc >= {1'b0, cfg.timeout_ticks}
                             && count_reg != '0)
                    begin
                        res_valid = 1'b1;
                        mode_next = (frame_res.status == ST_OK) ? MODE_OK : MODE_ERR;
                    end
                end
                ACT_REARM:
                begin
                    mode_next   = MODE_READ;
                    count_next  = '0;
                    idle_next   = '0;
                    sum_next    = '0;
                    last_next   = '0;
                    before_next = '0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_OFF;
            count_reg  <= '0;
            idle_reg   <= '0;
            sum_reg    <= '0;
            last_reg   <= '0;
            before_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            idle_reg   <= idle_next;
            sum_reg    <= sum_next;
            last_reg   <= last_next;
            before_reg <= before_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[count_reg[HDR_IDX_W-1:0]] <= item.byte_value;
        end
    end

endmodule

FILE: sv/ft12_out_stage.sv
// Result register that holds a check result until the sink takes it
`timescale 1ns / 1ps

module ft12_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic                   res_valid,
    input  ft12_pkg::ft12_result_t res,
    input  logic                   out_ready,
    output logic                   out_valid,
    output ft12_pkg::ft12_result_t out_res
);
    import ft12_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    ft12_result_t res_reg;

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule
